// ===== design/picp_pkg.sv =====
// Package for the point-in-convex-polygon classifier.
// Holds widths, defaults, position codes and the sequencer state type.
package picp_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int CNT_W            = 7;
    localparam int POS_W            = 2;

    typedef enum logic [1:0] {
        POS_INSIDE  = 2'd0,
        POS_ON      = 2'd1,
        POS_OUTSIDE = 2'd2
    } t_pos;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_CROSS,
        ST_DECIDE,
        ST_OUT
    } t_state;
endpackage

// ===== design/picp_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module picp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/point_in_convex_polygon.sv =====
// Top level: vertex table RAM plus binary-search sequencer over the triangle fan.
// Depends on picp_pkg and picp_ram.
// A vertex load writes the table when it is accepted. A query reads v0, v[m] and
// v[m+1] from the single RAM port and forms one cross product per cycle. A search
// has at most log2(MAX_VERTICES)+1 rounds of RD0, RD1, RD2, CROSS and DECIDE; then
// RD0 detects an exhausted search and OUT posts the word. The one-port table and the
// serial cross products set the length of a query. A result waiting on the output
// holds back only the next query's final step.
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = picp_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = picp_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [picp_pkg::CNT_W-1:0]   i_cfg_vertex_count,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [5:0]                   i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [picp_pkg::POS_W-1:0]   o_position
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = AW + 1;
    localparam int ROUNDS = AW + 1;
    localparam int RW = $clog2(ROUNDS + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int VW = 2 * COORD_BITS;

    picp_pkg::t_state r_state, n_state;
    logic [picp_pkg::CNT_W-1:0] r_count;
    logic [NW-1:0] r_lo, n_lo, r_hi, n_hi, r_n;
    logic [RW-1:0] r_round, n_round;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic signed [COORD_BITS-1:0] r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y;
    logic signed [CW-1:0] r_ca, r_c0, r_c1, r_c2;
    logic [1:0] r_cstep, n_cstep;
    logic [picp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [picp_pkg::POS_W-1:0] r_res;
    logic r_pend, n_pend;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [VW-1:0] ram_rdata;
    logic [NW-1:0] mid;
    logic [NW-1:0] n_clamp;
    logic signed [COORD_BITS-1:0] p2x, p2y;

    picp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_coord_x, i_coord_y}),
        .o_rdata(ram_rdata)
    );

    assign mid = NW'((({1'b0, r_lo} + {1'b0, r_hi}) >> 1));
    assign o_cfg_ready = (r_state == picp_pkg::ST_IDLE);
    assign o_ready = (r_state == picp_pkg::ST_IDLE);
    assign o_valid = r_pend;
    assign o_position = r_res;

    always_comb begin
        if (r_count < picp_pkg::CNT_W'(3)) begin
            n_clamp = NW'(3);
        end else if (32'(r_count) > MAX_VERTICES) begin
            n_clamp = NW'(MAX_VERTICES);
        end else begin
            n_clamp = NW'(r_count);
        end
    end

    // Take v[m+1] straight from the table on the first cross step.
    always_comb begin
        if (r_state == picp_pkg::ST_CROSS && r_cstep == 2'd0) begin
            p2x = $signed(ram_rdata[VW-1:COORD_BITS]);
            p2y = $signed(ram_rdata[COORD_BITS-1:0]);
        end else begin
            p2x = r_p2x;
            p2y = r_p2y;
        end
    end

    // Cross product terms: one product pair per cycle-step.
    logic signed [DW-1:0] ax, ay, bx, by;
    logic signed [PW-1:0] prod_a, prod_b;
    logic signed [CW-1:0] cross_val;
    always_comb begin
        ax = '0; ay = '0; bx = '0; by = '0;
        case (r_cstep)
            2'd0: begin
                ax = DW'(p2x) - DW'(r_p1x); ay = DW'(p2y) - DW'(r_p1y);
                bx = DW'(r_p0x) - DW'(r_p1x); by = DW'(r_p0y) - DW'(r_p1y);
            end
            2'd1: begin
                ax = DW'(p2x) - DW'(r_p1x); ay = DW'(p2y) - DW'(r_p1y);
                bx = DW'(r_qx) - DW'(r_p1x);  by = DW'(r_qy) - DW'(r_p1y);
            end
            2'd2: begin
                ax = DW'(r_p0x) - DW'(p2x); ay = DW'(r_p0y) - DW'(p2y);
                bx = DW'(r_qx) - DW'(p2x);  by = DW'(r_qy) - DW'(p2y);
            end
            default: begin
                ax = DW'(r_p1x) - DW'(r_p0x); ay = DW'(r_p1y) - DW'(r_p0y);
                bx = DW'(r_qx) - DW'(r_p0x);  by = DW'(r_qy) - DW'(r_p0y);
            end
        endcase
        prod_a = ax * by;
        prod_b = ay * bx;
        cross_val = CW'(prod_a) - CW'(prod_b);
    end

    function automatic logic signed [1:0] sgn(input logic signed [CW-1:0] v);
        sgn = (v == '0) ? 2'sd0 : (v[CW-1] ? -2'sd1 : 2'sd1);
    endfunction

    // Decision over the captured signs.
    logic signed [1:0] sa, s0, s1, s2;
    logic signed [DW-1:0] tq, td;
    logic hit, first, last, q_eq0;
    always_comb begin
        sa = sgn(r_ca);
        s0 = 2'(sa * sgn(r_c0));
        s1 = 2'(sa * sgn(r_c1));
        s2 = 2'(sa * sgn(r_c2));
        if (r_p1x == r_p2x) begin
            tq = DW'(r_qy) - DW'(r_p1y); td = DW'(r_p2y) - DW'(r_p1y);
        end else begin
            tq = DW'(r_qx) - DW'(r_p1x); td = DW'(r_p2x) - DW'(r_p1x);
        end
        if (td > 0) begin
            hit = (tq >= 0) && (tq <= td);
        end else if (td < 0) begin
            hit = (tq <= 0) && (tq >= td);
        end else begin
            hit = 1'b0;
        end
        first = (mid == NW'(1));
        last  = (mid == r_n - NW'(2));
        q_eq0 = (r_qx == r_p0x) && (r_qy == r_p0y);
    end

    always_comb begin
        n_state = r_state;
        n_lo = r_lo; n_hi = r_hi; n_round = r_round;
        n_cstep = r_cstep; n_pos = r_pos; n_pend = r_pend;
        ram_we = 1'b0;
        ram_addr = AW'(i_vertex_index);
        if (r_pend && i_ready) begin
            n_pend = 1'b0;
        end
        case (r_state)
            picp_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    if (!i_op) begin
                        ram_we = (32'(i_vertex_index) < MAX_VERTICES);
                    end else begin
                        n_lo = NW'(1);
                        n_hi = n_clamp - NW'(1);
                        n_round = '0;
                        n_state = picp_pkg::ST_RD0;
                    end
                end
            end
            picp_pkg::ST_RD0: begin
                if (r_round == RW'(ROUNDS) || !(r_hi > r_lo)) begin
                    n_pos = picp_pkg::POS_OUTSIDE;
                    n_state = picp_pkg::ST_OUT;
                end else begin
                    ram_addr = '0;
                    n_state = picp_pkg::ST_RD1;
                end
            end
            picp_pkg::ST_RD1: begin
                ram_addr = mid[AW-1:0];
                n_state = picp_pkg::ST_RD2;
            end
            picp_pkg::ST_RD2: begin
                ram_addr = AW'(mid + NW'(1));
                n_state = picp_pkg::ST_CROSS;
            end
            picp_pkg::ST_CROSS: begin
                n_cstep = r_cstep + 2'd1;
                if (r_cstep == 2'd3) begin
                    n_state = picp_pkg::ST_DECIDE;
                end
            end
            picp_pkg::ST_DECIDE: begin
                n_state = picp_pkg::ST_OUT;
                n_round = r_round + RW'(1);
                if (q_eq0) begin
                    n_pos = picp_pkg::POS_ON;
                end else if (s0 < 0) begin
                    n_pos = picp_pkg::POS_OUTSIDE;
                end else if (s0 == 0) begin
                    n_pos = hit ? picp_pkg::POS_ON : picp_pkg::POS_OUTSIDE;
                end else if (s2 == 0 && first && s1 >= 0) begin
                    n_pos = picp_pkg::POS_ON;
                end else if (s1 == 0 && last && s2 >= 0) begin
                    n_pos = picp_pkg::POS_ON;
                end else if (s1 >= 0 && s2 >= 0) begin
                    n_pos = picp_pkg::POS_INSIDE;
                end else if (s2 < 0) begin
                    if (first || s1 < 0) begin
                        n_pos = picp_pkg::POS_OUTSIDE;
                    end else begin
                        n_hi = mid;
                        n_state = picp_pkg::ST_RD0;
                    end
                end else begin
                    if (last) begin
                        n_pos = picp_pkg::POS_OUTSIDE;
                    end else begin
                        n_lo = mid;
                        n_state = picp_pkg::ST_RD0;
                    end
                end
            end
            picp_pkg::ST_OUT: begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                    n_state = picp_pkg::ST_IDLE;
                end
            end
            default: n_state = picp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= picp_pkg::ST_IDLE;
            r_count <= picp_pkg::CNT_W'(3);
            r_pend  <= 1'b0;
            r_cstep <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cstep <= n_cstep;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_vertex_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_round <= n_round;
        r_pos <= n_pos;
        if (r_state == picp_pkg::ST_OUT && !r_pend) begin
            r_res <= r_pos;
        end
        if (r_state == picp_pkg::ST_IDLE && i_valid && o_ready) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_n  <= n_clamp;
        end
        if (r_state == picp_pkg::ST_RD1) begin
            r_p0x <= ram_rdata[VW-1:COORD_BITS];
            r_p0y <= ram_rdata[COORD_BITS-1:0];
        end
        if (r_state == picp_pkg::ST_RD2) begin
            r_p1x <= ram_rdata[VW-1:COORD_BITS];
            r_p1y <= ram_rdata[COORD_BITS-1:0];
        end
        if (r_state == picp_pkg::ST_CROSS && r_cstep == 2'd0) begin
            r_p2x <= p2x;
            r_p2y <= p2y;
        end
        if (r_state == picp_pkg::ST_CROSS) begin
            case (r_cstep)
                2'd0: r_ca <= cross_val;
                2'd1: r_c0 <= cross_val;
                2'd2: r_c1 <= cross_val;
                default: r_c2 <= cross_val;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position));
    a_cstep_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != picp_pkg::ST_CROSS |-> r_cstep == 2'd0);
    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == picp_pkg::ST_RD1 |-> r_lo >= NW'(1) && r_hi > r_lo && r_hi < r_n);
`endif
endmodule

// ===== test/point_in_convex_polygon_tb.sv =====
// Self-checking testbench for point_in_convex_polygon: loads polygons, queries points.
// Predicts each position with its own fan-of-triangles search; needs picp_pkg and the RTL.
module point_in_convex_polygon_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int SEARCH_ROUNDS = 7;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1750;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum {STEP_ON, STEP_IN, STEP_OUT, STEP_LEFT, STEP_RIGHT} t_step;

    class position_board;
        longint vx[SLOTS];
        longint vy[SLOTS];
        int count;
        picp_pkg::t_pos expected_q[$];
        int errors;
        int tally[3];

        function new();
            foreach (vx[i]) begin
                vx[i] = 0;
                vy[i] = 0;
            end
            count = 3;
            errors = 0;
            tally = '{0, 0, 0};
        endfunction

        function void set_count(int c);
            count = c;
        endfunction

        function int sgn(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function int orient(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
            return sgn((bx - ax) * (cy - ay) - (by - ay) * (cx - ax));
        endfunction

        function bit in_span(longint t, longint d);
            if (d > 0) return t >= 0 && t <= d;
            if (d < 0) return t <= 0 && t >= d;
            return 0;
        endfunction

        function t_step probe(longint qx, longint qy, int m, int n);
            int a, s0, s1, s2;
            bit hit;
            if (qx == vx[0] && qy == vy[0]) return STEP_ON;
            a = orient(vx[m], vy[m], vx[m+1], vy[m+1], vx[0], vy[0]);
            s0 = a * orient(vx[m], vy[m], vx[m+1], vy[m+1], qx, qy);
            s1 = a * orient(vx[m+1], vy[m+1], vx[0], vy[0], qx, qy);
            s2 = a * orient(vx[0], vy[0], vx[m], vy[m], qx, qy);
            if (s0 < 0) return STEP_OUT;
            if (s0 == 0) begin
                if (vx[m] == vx[m+1]) hit = in_span(qy - vy[m], vy[m+1] - vy[m]);
                else hit = in_span(qx - vx[m], vx[m+1] - vx[m]);
                return hit ? STEP_ON : STEP_OUT;
            end
            if (s2 == 0 && m == 1 && s1 >= 0) return STEP_ON;
            if (s1 == 0 && m == n - 2 && s2 >= 0) return STEP_ON;
            if (s1 >= 0 && s2 >= 0) return STEP_IN;
            if (s2 < 0) return (m == 1 || s1 < 0) ? STEP_OUT : STEP_LEFT;
            if (s1 < 0) return (m == n - 2 || s2 < 0) ? STEP_OUT : STEP_RIGHT;
            return STEP_OUT;
        endfunction

        function picp_pkg::t_pos classify(longint qx, longint qy);
            int n, lo, hi, mid;
            t_step r;
            n = (count < 3) ? 3 : ((count > SLOTS) ? SLOTS : count);
            lo = 1;
            hi = n - 1;
            mid = (lo + hi) / 2;
            for (int k = 0; k < SEARCH_ROUNDS && hi > lo; k++) begin
                r = probe(qx, qy, mid, n);
                if (r == STEP_ON) return picp_pkg::POS_ON;
                if (r == STEP_IN) return picp_pkg::POS_INSIDE;
                if (r == STEP_OUT) return picp_pkg::POS_OUTSIDE;
                if (r == STEP_LEFT) hi = mid;
                else lo = mid;
                mid = (lo + hi) / 2;
            end
            return picp_pkg::POS_OUTSIDE;
        endfunction

        function void note_word(logic op, int idx, longint x, longint y);
            picp_pkg::t_pos p;
            if (op == OP_LOAD) begin
                vx[idx] = x;
                vy[idx] = y;
            end else begin
                p = classify(x, y);
                tally[p]++;
                expected_q = {expected_q, p};
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_position(logic [picp_pkg::POS_W-1:0] got);
            picp_pkg::t_pos want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected position %0d", got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) report($sformatf("position %0d, want %0d", got, want));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [picp_pkg::CNT_W-1:0] i_cfg_vertex_count = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_op = OP_LOAD;
    logic [5:0] i_vertex_index = '0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [picp_pkg::POS_W-1:0] o_position;

    position_board board = new();
    bit calm = 0;
    int cycles = 0;
    int items = 0;
    int phases = 0;
    longint px[SLOTS];
    longint py[SLOTS];

    point_in_convex_polygon DUT (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL point_in_convex_polygon");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 12);
        if (i_rst_n && o_valid && i_ready) board.check_position(o_position);
    end

    task automatic send_word(logic op, int idx, longint x, longint y);
        if (!calm && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_vertex_index <= idx[5:0];
        i_coord_x <= x[15:0];
        i_coord_y <= y[15:0];
        do @(posedge i_clk); while (!o_ready);
        board.note_word(op, idx, x, y);
        items++;
    endtask

    task automatic set_vertex_count(int c);
        i_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_vertex_count <= c[picp_pkg::CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_count(c);
        phases++;
    endtask

    function automatic longint clip(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic longint gcd(longint a, longint b);
        longint t;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic load_polygon(int n, bit messy);
        real r, base, ang;
        longint cx, cy;
        bit flip;
        cx = longint'($urandom_range(40000)) - 20000;
        cy = longint'($urandom_range(40000)) - 20000;
        r = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(20, 30000);
        base = $urandom_range(6283) / 1000.0;
        flip = $urandom_range(1);
        for (int k = 0; k < n; k++) begin
            ang = base + (flip ? -1.0 : 1.0) * 6.2831853 * k / n;
            px[k] = messy ? longint'($urandom_range(65535)) - 32768 : clip(cx + $rtoi(r * $cos(ang)));
            py[k] = messy ? longint'($urandom_range(65535)) - 32768 : clip(cy + $rtoi(r * $sin(ang)));
        end
        for (int k = 0; k < n; k++) send_word(OP_LOAD, k, px[k], py[k]);
        repeat ($urandom_range(0, 3))
            send_word(OP_LOAD, $urandom_range(n, SLOTS - 1) % SLOTS,
                      longint'($urandom_range(65535)) - 32768,
                      longint'($urandom_range(65535)) - 32768);
    endtask

    task automatic query_polygon(int n, int total);
        int k, j, pick;
        longint dx, dy, g, qx, qy;
        for (int q = 0; q < total; q++) begin
            k = $urandom_range(n - 1);
            pick = $urandom_range(99);
            if (pick < 20) begin
                qx = px[k];
                qy = py[k];
            end else if (pick < 45) begin
                dx = px[(k + 1) % n] - px[k];
                dy = py[(k + 1) % n] - py[k];
                g = gcd(dx, dy);
                j = (g == 0) ? 0 : $urandom_range(g);
                qx = (g == 0) ? px[k] : px[k] + j * (dx / g);
                qy = (g == 0) ? py[k] : py[k] + j * (dy / g);
            end else if (pick < 55) begin
                qx = clip(px[k] + longint'($urandom_range(2)) - 1);
                qy = clip(py[k] + longint'($urandom_range(2)) - 1);
            end else if (pick < 90) begin
                qx = clip((px[0] + px[n / 2]) / 2 + longint'($urandom_range(200)) - 100);
                qy = clip((py[0] + py[n / 2]) / 2 + longint'($urandom_range(200)) - 100);
            end else begin
                qx = longint'($urandom_range(65535)) - 32768;
                qy = longint'($urandom_range(65535)) - 32768;
            end
            send_word(OP_QUERY, $urandom_range(63), qx, qy);
        end
    endtask

    initial begin
        int extremes[8] = '{127, 64, 3, 0, 1, 2, 65, 4};
        int c, n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_vertex_count(3);
        send_word(OP_LOAD, 0, -32768, -32768);
        send_word(OP_LOAD, 1, 32767, -32768);
        send_word(OP_LOAD, 2, 0, 32767);
        send_word(OP_QUERY, 63, -32768, -32768);
        send_word(OP_QUERY, 0, 32767, -32768);
        send_word(OP_QUERY, 0, 0, 32767);
        send_word(OP_QUERY, 0, 0, -32768);
        send_word(OP_QUERY, 0, 0, 0);
        send_word(OP_QUERY, 0, 32767, 32767);
        send_word(OP_QUERY, 0, -32768, 32767);
        send_word(OP_LOAD, 1, 10, 10);
        send_word(OP_LOAD, 2, 20, 20);
        send_word(OP_LOAD, 0, 0, 0);
        send_word(OP_QUERY, 0, 5, 5);
        send_word(OP_QUERY, 0, 15, 15);
        send_word(OP_QUERY, 0, 25, 25);
        send_word(OP_QUERY, 0, 1, 0);
        send_word(OP_LOAD, 1, 7, 7);
        send_word(OP_LOAD, 2, 7, 7);
        send_word(OP_QUERY, 0, 7, 7);
        send_word(OP_QUERY, 0, 3, 3);
        send_word(OP_QUERY, 0, 0, 0);

        for (int ph = 0; items < ITEM_TARGET; ph++) begin
            if (ph < 8) c = extremes[ph];
            else if ($urandom_range(9) == 0) c = $urandom_range(127);
            else c = $urandom_range(3, 64);
            set_vertex_count(c);
            calm = (ph == 4);
            n = (c < 3) ? 3 : ((c > SLOTS) ? SLOTS : c);
            load_polygon(ph == 0 ? SLOTS : n, ph > 8 && $urandom_range(7) == 0);
            query_polygon(n, 40);
        end
        calm = 0;
        i_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d words over %0d vertex-count settings", items, phases);
        $display("positions seen: %0d inside, %0d on boundary, %0d outside",
                 board.tally[0], board.tally[1], board.tally[2]);
        if (board.errors == 0) begin
            $display("PASS point_in_convex_polygon");
        end else begin
            $display("FAIL point_in_convex_polygon");
        end
        $finish;
    end
endmodule

// ===== point_in_convex_polygon.f =====
design/picp_pkg.sv
design/picp_ram.sv
design/point_in_convex_polygon.sv
test/point_in_convex_polygon_tb.sv
